// ----- design/ctrj_pkg.sv -----
// ctrj_pkg: types, widths and codes shared by the cubic trajectory generator
// used by ctrj_ctrl, ctrj_dp and cubic_rest_to_rest_trajectory
// no dependencies
package ctrj_pkg;

  localparam int unsigned CoordW  = 32;   // Q16.16 coordinate width
  localparam int unsigned IndexW  = 16;   // step index and step count width
  localparam int unsigned FracW   = 31;   // fraction bits of s, s^2 and h
  localparam int unsigned MagW    = CoordW + 1;
  localparam int unsigned MulW    = (MagW > FracW + 2) ? MagW : FracW + 2;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned SumW    = CoordW + 2;
  localparam int unsigned DivCntW = $clog2(FracW);

  localparam logic [IndexW-1:0] StepCountRst = IndexW'(1000);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] start_z;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic signed [CoordW-1:0] end_z;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] sample_x;
    logic signed [CoordW-1:0] sample_y;
    logic signed [CoordW-1:0] sample_z;
    logic        [IndexW-1:0] step_index;
    logic                     last;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQ,
    ST_CUBE,
    ST_MX,
    ST_MY,
    ST_MZ,
    ST_DONE
  } ctrl_state_e;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_SQ,
    MUL_CUBE,
    MUL_X,
    MUL_Y,
    MUL_Z
  } mul_sel_e;

  typedef enum logic [1:0] {
    CAP_NONE,
    CAP_X,
    CAP_Y
  } cap_sel_e;

  typedef struct packed {
    logic     load;
    logic     tick_start;
    logic     div_step;
    mul_sel_e mul_sel;
    cap_sel_e cap_sel;
    logic     out_write;
  } ctrj_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } ctrj_status_t;

endpackage

// ----- design/ctrj_ctrl.sv -----
// ctrj_ctrl: sequencer for one tick (divide, square, blend, three scale steps, write)
// depends on ctrj_pkg
module ctrj_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_op_i,
  output logic                  in_ready_o,
  input  ctrj_pkg::ctrj_status_t status_i,
  output ctrj_pkg::ctrj_cmd_t    cmd_o
);
  import ctrj_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (in_op_i == OP_TICK)) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_SQ;
      end
      ST_SQ:   state_d = ST_CUBE;
      ST_CUBE: state_d = ST_MX;
      ST_MX:   state_d = ST_MY;
      ST_MY:   state_d = ST_MZ;
      ST_MZ:   state_d = ST_DONE;
      ST_DONE: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.mul_sel    = MUL_NONE;
    cmd_o.cap_sel    = CAP_NONE;
    case (state_q)
      ST_IDLE: begin
        in_ready_o       = 1'b1;
        cmd_o.load       = in_valid_i && (in_op_i == OP_LOAD);
        cmd_o.tick_start = in_valid_i && (in_op_i == OP_TICK);
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_SQ:   cmd_o.mul_sel  = MUL_SQ;
      ST_CUBE: cmd_o.mul_sel  = MUL_CUBE;
      ST_MX:   cmd_o.mul_sel  = MUL_X;
      ST_MY: begin
        cmd_o.mul_sel = MUL_Y;
        cmd_o.cap_sel = CAP_X;
      end
      ST_MZ: begin
        cmd_o.mul_sel = MUL_Z;
        cmd_o.cap_sel = CAP_Y;
      end
      ST_DONE: cmd_o.out_write = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

// ----- design/ctrj_dp.sv -----
// ctrj_dp: endpoint store, step counter, restoring divider, shared multiplier,
// saturating adder and output register; depends on ctrj_pkg
module ctrj_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctrj_pkg::in_item_t             in_item_i,
  input  logic                          cfg_valid_i,
  input  logic [ctrj_pkg::IndexW-1:0]   cfg_step_count_i,
  input  ctrj_pkg::ctrj_cmd_t            cmd_i,
  output ctrj_pkg::ctrj_status_t         status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ctrj_pkg::out_item_t            out_item_o
);
  import ctrj_pkg::*;

  function automatic logic [MagW-1:0] mag_of(input logic [MagW-1:0] d);
    mag_of = d[MagW-1] ? (~d + MagW'(1)) : d;
  endfunction

  // endpoint state
  logic signed [CoordW-1:0] start_q [3];
  logic signed [MagW-1:0]   delta_q [3];
  logic [IndexW-1:0]        step_count_q, count_q;

  // per tick state
  logic [IndexW-1:0]  n_q, k_q;
  logic               last_q;
  logic [IndexW:0]    rem_q;
  logic [FracW-1:0]   quo_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [ProdW-1:0]   prod_q;
  logic [FracW-1:0]   h_q;
  logic [CoordW-1:0]  res_x_q, res_y_q;

  logic               out_valid_q;
  out_item_t          out_item_q;

  // step index clamp
  logic [IndexW-1:0] n_eff, n_m1, k_eff;
  logic              k_last;

  always_comb begin
    n_eff  = (step_count_q == '0) ? IndexW'(1) : step_count_q;
    n_m1   = n_eff - IndexW'(1);
    k_eff  = (count_q > n_m1) ? n_m1 : count_q;
    k_last = (k_eff == n_m1);
  end

  // one quotient bit per cycle
  logic [IndexW:0] rem_shift, rem_diff;
  logic            rem_ge;

  always_comb begin
    rem_shift = {rem_q[IndexW-1:0], 1'b0};
    rem_ge    = (rem_shift >= {1'b0, n_q});
    rem_diff  = rem_shift - {1'b0, n_q};
  end

  // shared multiplier
  logic [MulW-1:0]  mul_a, mul_b, g_val;
  logic [ProdW-1:0] mul_rnd, prod_d;
  logic [FracW-1:0] prod_mid;
  logic             prod_we;

  always_comb begin
    prod_mid = prod_q[2*FracW-1:FracW];
    g_val    = (MulW'(3) << FracW) - (MulW'(quo_q) << 1);
    mul_a    = '0;
    mul_b    = '0;
    mul_rnd  = '0;
    prod_we  = 1'b1;
    case (cmd_i.mul_sel)
      MUL_SQ: begin
        mul_a = MulW'(quo_q);
        mul_b = MulW'(quo_q);
      end
      MUL_CUBE: begin
        mul_a = MulW'(prod_mid);
        mul_b = g_val;
      end
      MUL_X: begin
        mul_a   = MulW'(mag_of(delta_q[0]));
        mul_b   = MulW'(prod_mid);
        mul_rnd = ProdW'(1) << (FracW - 1);
      end
      MUL_Y: begin
        mul_a   = MulW'(mag_of(delta_q[1]));
        mul_b   = MulW'(h_q);
        mul_rnd = ProdW'(1) << (FracW - 1);
      end
      MUL_Z: begin
        mul_a   = MulW'(mag_of(delta_q[2]));
        mul_b   = MulW'(h_q);
        mul_rnd = ProdW'(1) << (FracW - 1);
      end
      default: prod_we = 1'b0;
    endcase
    prod_d = ProdW'(mul_a) * ProdW'(mul_b) + mul_rnd;
  end

  // signed add of the scaled term with saturation
  logic [1:0]              comp;
  logic [MagW-1:0]         term;
  logic [SumW-1:0]         start_ext, term_ext, sum;
  logic [CoordW-1:0]       res_sat;

  always_comb begin
    case (cmd_i.cap_sel)
      CAP_X:   comp = 2'd0;
      CAP_Y:   comp = 2'd1;
      default: comp = 2'd2;
    endcase
    term      = prod_q[FracW+MagW-1:FracW];
    start_ext = {{2{start_q[comp][CoordW-1]}}, start_q[comp]};
    term_ext  = {1'b0, term};
    sum       = delta_q[comp][MagW-1] ? (start_ext - term_ext) : (start_ext + term_ext);
    if (sum[SumW-1:CoordW-1] == '0 || sum[SumW-1:CoordW-1] == '1) begin
      res_sat = sum[CoordW-1:0];
    end else if (sum[SumW-1]) begin
      res_sat = {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      res_sat = {1'b0, {(CoordW-1){1'b1}}};
    end
  end

  always_comb begin
    status_o.div_done = (div_cnt_q == DivCntW'(FracW - 1));
    status_o.out_free = !out_valid_q || out_ready_i;
  end

  // control-relevant state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        start_q[i] <= '0;
        delta_q[i] <= '0;
      end
      step_count_q <= StepCountRst;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) step_count_q <= cfg_step_count_i;
      if (cmd_i.load) begin
        start_q[0] <= in_item_i.start_x;
        start_q[1] <= in_item_i.start_y;
        start_q[2] <= in_item_i.start_z;
        delta_q[0] <= MagW'(in_item_i.end_x) - MagW'(in_item_i.start_x);
        delta_q[1] <= MagW'(in_item_i.end_y) - MagW'(in_item_i.start_y);
        delta_q[2] <= MagW'(in_item_i.end_z) - MagW'(in_item_i.start_z);
        count_q    <= '0;
      end else if (cmd_i.tick_start) begin
        count_q <= k_last ? k_eff : (k_eff + IndexW'(1));
      end
      if (cmd_i.out_write) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      n_q       <= n_eff;
      k_q       <= k_eff;
      last_q    <= k_last;
      rem_q     <= {1'b0, k_eff};
      quo_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= rem_ge ? rem_diff : rem_shift;
      quo_q     <= {quo_q[FracW-2:0], rem_ge};
      div_cnt_q <= div_cnt_q + DivCntW'(1);
    end
    if (prod_we) prod_q <= prod_d;
    if (cmd_i.mul_sel == MUL_X) h_q <= prod_mid;
    if (cmd_i.cap_sel == CAP_X) res_x_q <= res_sat;
    if (cmd_i.cap_sel == CAP_Y) res_y_q <= res_sat;
    if (cmd_i.out_write) begin
      out_item_q.sample_x   <= res_x_q;
      out_item_q.sample_y   <= res_y_q;
      out_item_q.sample_z   <= res_sat;
      out_item_q.step_index <= k_q;
      out_item_q.last       <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

// ----- design/cubic_rest_to_rest_trajectory.sv -----
// cubic_rest_to_rest_trajectory: one channel of a rest-to-rest cubic trajectory
// sequence: a tick item is accepted in idle, then the divider runs and the multiply
// steps follow; its result is registered once the output register is free
// acceptance: a new item is taken only in idle, after the previous tick is written,
// due to the one-bit-per-cycle divider and the single shared multiplier
// reset: asynchronous active low, endpoints and step counter clear, step_count 1000
module cubic_rest_to_rest_trajectory (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input items: load endpoints or tick
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  ctrj_pkg::in_item_t            in_item_i,
  // result items: one per tick
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ctrj_pkg::out_item_t           out_item_o,
  // step_count register write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ctrj_pkg::IndexW-1:0]  cfg_step_count_i
);
  import ctrj_pkg::*;

  ctrj_cmd_t    cmd;
  ctrj_status_t status;

  // register writes are taken directly, so the port is always open
  assign cfg_ready_o = 1'b1;

  // sequencer: idle, divide k/N into s, s^2, blend h, then scale x, y, z
  ctrj_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_item_i.op),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: the output register parts the result from the next item,
  // so a finished sample can wait while a following load is taken
  ctrj_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_item_i        (in_item_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_step_count_i (cfg_step_count_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_item_o       (out_item_o)
  );

endmodule
